// ----- src/imvm_pkg.sv -----
// Shared types and constants for the int8 matrix-vector multiply-accumulate block.
// It depends on nothing else. The MAC unit and the top level import it; imvm_ram does not.
package imvm_pkg;

    localparam int MAX_FEATURES_DEF = 256;
    localparam int MAX_OUTPUTS_DEF  = 16;

    localparam int VALUE_W  = 8;
    localparam int SUM_W    = 24;
    localparam int COLUMN_W = 4;
    localparam int FC_W     = 9;
    localparam int OC_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [FC_W-1:0] FC_RESET = 9'd256;
    localparam logic [OC_W-1:0] OC_RESET = 5'd16;

    localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT  = 2'd1;

    localparam logic MODE_WEIGHT = 1'b0;
    localparam logic MODE_ACT    = 1'b1;

    typedef struct packed {
        logic                      mode;
        logic signed [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [COLUMN_W-1:0]     column;
        logic                    last;
    } t_out_item;

endpackage

// ----- src/imvm_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// It depends on no package.
module imvm_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/imvm_mac.sv -----
// Shared multiply-accumulate unit: one signed 8x8 product added to one accumulator.
// It depends on imvm_pkg for the value and sum widths.
module imvm_mac (
    input  logic signed [imvm_pkg::VALUE_W-1:0] i_act,
    input  logic signed [imvm_pkg::VALUE_W-1:0] i_weight,
    input  logic signed [imvm_pkg::SUM_W-1:0]   i_acc,
    input  logic                                i_acc_vld,
    output logic signed [imvm_pkg::SUM_W-1:0]   o_sum
);
    import imvm_pkg::*;

    logic signed [2*VALUE_W-1:0] w_prod;
    logic signed [SUM_W-1:0]     w_acc;

    always_comb begin
        w_prod = i_act * i_weight;
        // An accumulator that was never written since its last clear reads as zero.
        w_acc  = i_acc_vld ? i_acc : '0;
        o_sum  = w_acc + SUM_W'(w_prod);
    end

endmodule

// ----- src/int8_matrix_vector_mac.sv -----
// Signed 8-bit matrix-vector multiply with the weights held in an internal RAM. A weight
// transaction goes through S_WSIZE and S_WRITE; an activation goes through S_MAC, where
// the single shared multiply-accumulate unit visits one accumulator per cycle, then S_MEND.
// After the last feature of a row, each of the output_count sums goes through S_EMRD,
// S_EMLD and S_EMWAIT, held by any output stall. Register writes are accepted only while the
// block is idle and no input transaction is offered. Depends on imvm_pkg, imvm_ram, imvm_mac.
module int8_matrix_vector_mac #(
    parameter int MAX_FEATURES = imvm_pkg::MAX_FEATURES_DEF,
    parameter int MAX_OUTPUTS  = imvm_pkg::MAX_OUTPUTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  imvm_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output imvm_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [imvm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [imvm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import imvm_pkg::*;

    localparam int DEPTH = MAX_FEATURES * MAX_OUTPUTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SZW   = $clog2(DEPTH + 1);
    localparam int NFW   = $clog2(MAX_FEATURES + 1);
    localparam int NOW   = $clog2(MAX_OUTPUTS + 1);
    localparam int FPW   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int CW    = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WSIZE,
        S_WRITE,
        S_MAC,
        S_MEND,
        S_EMRD,
        S_EMLD,
        S_EMWAIT
    } t_state;

    t_state                    r_state;
    logic [FC_W-1:0]           r_fc;
    logic [OC_W-1:0]           r_oc;
    logic signed [VALUE_W-1:0] r_val;
    logic [SZW-1:0]            r_size;
    logic [AW-1:0]             r_wptr;
    logic [FPW-1:0]            r_fp;
    logic [AW-1:0]             r_waddr;
    logic [CW-1:0]             r_col;
    logic                      r_p_vld;
    logic [CW-1:0]             r_p_col;
    logic [MAX_OUTPUTS-1:0]    r_acc_vld;
    logic                      r_rd_vld;
    logic                      r_out_vld;
    t_out_item                 r_out;

    logic [NFW-1:0]            w_nf;
    logic [NOW-1:0]            w_no;
    logic [AW-1:0]             w_wp_eff;
    logic [SZW-1:0]            w_wp_inc;
    logic [AW-1:0]             n_wptr;
    logic [FPW-1:0]            w_fp_eff;
    logic                      w_col_last;
    logic                      w_row_done;
    logic [AW-1:0]             n_waddr;
    logic signed [VALUE_W-1:0] w_wdata;
    logic signed [SUM_W-1:0]   w_acc_rd;
    logic signed [SUM_W-1:0]   w_sum;
    logic                      w_in_acc;

    // Register values out of range are used clamped to the supported range.
    always_comb begin
        if (r_fc == '0) begin
            w_nf = NFW'(1);
        end else if (32'(r_fc) > MAX_FEATURES) begin
            w_nf = NFW'(MAX_FEATURES);
        end else begin
            w_nf = NFW'(r_fc);
        end
        if (r_oc == '0) begin
            w_no = NOW'(1);
        end else if (32'(r_oc) > MAX_OUTPUTS) begin
            w_no = NOW'(MAX_OUTPUTS);
        end else begin
            w_no = NOW'(r_oc);
        end
    end

    always_comb begin
        w_wp_eff   = (SZW'(r_wptr) >= r_size) ? '0 : r_wptr;
        w_wp_inc   = SZW'(w_wp_eff) + SZW'(1);
        n_wptr     = (w_wp_inc >= r_size) ? '0 : AW'(w_wp_inc);
        w_fp_eff   = (32'(r_fp) >= 32'(w_nf)) ? FPW'(32'(w_nf) - 1) : r_fp;
        w_col_last = (32'(r_col) + 1 == 32'(w_no));
        w_row_done = (32'(r_fp) + 1 >= 32'(w_nf));
        n_waddr    = AW'(32'(r_waddr) + 32'(w_nf));
        w_in_acc   = i_in_valid && !o_in_stall;
    end

    imvm_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(DEPTH),
        .ADDR_W(AW)
    ) u_weight_ram (
        .i_clk  (i_clk),
        .i_we   (r_state == S_WRITE),
        .i_waddr(w_wp_eff),
        .i_wdata(r_val),
        .i_raddr(r_waddr),
        .o_rdata(w_wdata)
    );

    imvm_ram #(
        .WIDTH(SUM_W),
        .DEPTH(MAX_OUTPUTS),
        .ADDR_W(CW)
    ) u_acc_ram (
        .i_clk  (i_clk),
        .i_we   (r_p_vld),
        .i_waddr(r_p_col),
        .i_wdata(w_sum),
        .i_raddr(r_col),
        .o_rdata(w_acc_rd)
    );

    imvm_mac u_mac (
        .i_act    (r_val),
        .i_weight (w_wdata),
        .i_acc    (w_acc_rd),
        .i_acc_vld(r_rd_vld),
        .o_sum    (w_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fc      <= FC_RESET;
            r_oc      <= OC_RESET;
            r_wptr    <= '0;
            r_fp      <= '0;
            r_col     <= '0;
            r_p_vld   <= 1'b0;
            r_acc_vld <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_FEATURE_COUNT: r_fc <= i_cfg_data[FC_W-1:0];
                    CFG_OUTPUT_COUNT:  r_oc <= i_cfg_data[OC_W-1:0];
                    default: ;
                endcase
            end

            // Accumulator read data is registered, and its valid bit is registered alongside it.
            r_rd_vld <= r_acc_vld[r_col];
            r_p_vld  <= (r_state == S_MAC);
            if (r_p_vld) begin
                r_acc_vld[r_p_col] <= 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_val <= i_in_data.value;
                        if (i_in_data.mode == MODE_ACT) begin
                            r_fp    <= w_fp_eff;
                            r_waddr <= AW'(w_fp_eff);
                            r_col   <= '0;
                            r_state <= S_MAC;
                        end else begin
                            r_state <= S_WSIZE;
                        end
                    end
                end
                S_WSIZE: begin
                    r_size  <= SZW'(w_nf) * SZW'(w_no);
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    r_wptr  <= n_wptr;
                    r_state <= S_IDLE;
                end
                S_MAC: begin
                    // One column is issued per cycle; its update is written in the following cycle.
                    r_p_col <= r_col;
                    r_waddr <= n_waddr;
                    if (w_col_last) begin
                        r_col   <= '0;
                        r_state <= S_MEND;
                    end else begin
                        r_col <= r_col + CW'(1);
                    end
                end
                S_MEND: begin
                    if (w_row_done) begin
                        r_fp    <= '0;
                        r_state <= S_EMRD;
                    end else begin
                        r_fp    <= r_fp + FPW'(1);
                        r_state <= S_IDLE;
                    end
                end
                S_EMRD: begin
                    r_state <= S_EMLD;
                end
                S_EMLD: begin
                    r_out.sum    <= r_rd_vld ? w_acc_rd : '0;
                    r_out.column <= COLUMN_W'(r_col);
                    r_out.last   <= w_col_last;
                    r_out_vld    <= 1'b1;
                    r_state      <= S_EMWAIT;
                end
                S_EMWAIT: begin
                    if (!i_out_stall) begin
                        r_out_vld <= 1'b0;
                        if (r_out.last) begin
                            r_col     <= '0;
                            r_acc_vld <= '0;
                            r_state   <= S_IDLE;
                        end else begin
                            r_col   <= r_col + CW'(1);
                            r_state <= S_EMRD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign o_cfg_ready = (r_state == S_IDLE) && !i_in_valid;

endmodule
